// ----- sv/spectral_model_evaluator_macros.svh -----
// Assertion helpers shared by the evaluator RTL.
`ifndef SPECTRAL_MODEL_EVALUATOR_MACROS_SVH
`define SPECTRAL_MODEL_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SME_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("spectral model evaluator: implication check failed");

// Next-cycle implication, checked out of reset.
`define SME_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("spectral model evaluator: next-cycle check failed");

`endif

// ----- sv/sme_pkg.sv -----
package sme_pkg;

    localparam int LOG_FRAC  = 24;   // fraction bits of log-domain values
    localparam int LOG_STEPS = 24;   // squaring steps in the log unit
    localparam int LOG_W     = 31;   // signed log2 result width
    localparam int COEF_REGS = 4;
    localparam int CFG_IDX_W = 3;
    localparam logic [23:0] LN2_Q24 = 24'd11629080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_REF_FREQ   = 3'd1,
        REG_COEF_ZERO  = 3'd2,
        REG_COEF_ONE   = 3'd3,
        REG_COEF_TWO   = 3'd4,
        REG_COEF_THREE = 3'd5,
        REG_TERM_COUNT = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SAT    = 2'd1,
        ST_DOMAIN = 2'd2
    } t_status;

    typedef enum logic {
        MODE_POWER_LAW  = 1'b0,
        MODE_POLYNOMIAL = 1'b1
    } t_mode;

    // Result decided ahead of the exponential (polynomial mode and special cases).
    typedef struct packed {
        logic        fixed;
        logic [31:0] flux;
        t_status     status;
    } t_override;

    typedef struct packed {
        logic [31:0] flux;
        logic        sat;
    } t_poly_res;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        int          i;
        rem  = x;
        root = 64'd0;
        b    = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > rem) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (rem >= root + b) begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
        end
        return root;
    endfunction

    // 2^(2^-k) in Q1.30, built by repeated square roots from 2.0
    function automatic logic [31:0] root_entry(input int k);
        logic [63:0] t;
        int          j;
        t = 64'd1 << 31;
        for (j = 1; j <= LOG_FRAC; j++) begin
            if (j <= k) begin
                t = isqrt64(t << 30);
            end
        end
        return t[31:0];
    endfunction

endpackage

// ----- sv/sme_log2.sv -----
module sme_log2 #(
    parameter int LANES     = 3,
    parameter int SIDE_W    = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [31:0]                         i_x [LANES],
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic signed [sme_pkg::LOG_W-1:0]    o_log [LANES],
    output logic [SIDE_W-1:0]                   o_side
);
    import sme_pkg::*;

    localparam logic signed [LOG_W-1:0] BIAS = LOG_W'(FRAC_BITS * (1 << LOG_FRAC));

    logic              r_v    [0:LOG_STEPS];
    logic [SIDE_W-1:0] r_side [0:LOG_STEPS];
    logic [30:0]       r_m    [0:LOG_STEPS][LANES];
    logic [4:0]        r_e    [0:LOG_STEPS][LANES];
    logic [LOG_FRAC-1:0] r_fr [0:LOG_STEPS][LANES];

    logic [4:0]  msb  [LANES];
    logic [30:0] norm [LANES];

    // leading-one search and normalize to Q1.30
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            msb[l] = 5'd0;
            for (int i = 0; i < 32; i++) begin
                if (i_x[l][i]) begin
                    msb[l] = 5'(i);
                end
            end
            norm[l] = 31'({i_x[l], 30'b0} >> msb[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_side[0] <= i_side;
        for (int l = 0; l < LANES; l++) begin
            r_m[0][l]  <= norm[l];
            r_e[0][l]  <= msb[l];
            r_fr[0][l] <= '0;
        end
    end

    // one fraction bit per stage: square, renormalize
    for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_step
        logic [61:0] sq   [LANES];
        logic [31:0] half [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                sq[l]   = 62'(r_m[k-1][l]) * 62'(r_m[k-1][l]);
                half[l] = sq[l][61:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_side[k] <= r_side[k-1];
            for (int l = 0; l < LANES; l++) begin
                r_e[k][l]  <= r_e[k-1][l];
                r_m[k][l]  <= half[l][31] ? half[l][31:1] : half[l][30:0];
                r_fr[k][l] <= {r_fr[k-1][l][LOG_FRAC-2:0], half[l][31]};
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_log[l] = LOG_W'($signed({1'b0, r_e[LOG_STEPS][l], r_fr[LOG_STEPS][l]})) - BIAS;
        end
    end

    assign o_valid = r_v[LOG_STEPS];
    assign o_side  = r_side[LOG_STEPS];

endmodule

// ----- sv/sme_exp2.sv -----
module sme_exp2 #(
    parameter int SIDE_W = 35
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [sme_pkg::LOG_FRAC-1:0]  i_frac,
    input  logic [4:0]                    i_shift,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [31:0]                   o_value,
    output logic [SIDE_W-1:0]             o_side
);
    import sme_pkg::*;

    localparam int STEPS = LOG_FRAC;

    logic                r_v    [0:STEPS+1];
    logic [SIDE_W-1:0]   r_side [0:STEPS+1];
    logic [31:0]         r_p    [0:STEPS];
    logic [4:0]          r_s    [0:STEPS];
    logic [LOG_FRAC-1:0] r_fr   [0:STEPS-1];
    logic [31:0]         r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_side[0] <= i_side;
        r_p[0]    <= 32'd1 << 30;
        r_s[0]    <= i_shift;
        r_fr[0]   <= i_frac;
    end

    // stage k multiplies by 2^(2^-k) when that fraction bit is set
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam logic [31:0] ROOT = root_entry(k);
        logic [63:0] prod;
        logic        bit_set;

        assign bit_set = r_fr[k-1][LOG_FRAC-k];
        assign prod    = 64'(r_p[k-1]) * 64'(ROOT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_side[k] <= r_side[k-1];
            r_s[k]    <= r_s[k-1];
            r_p[k]    <= bit_set ? 32'((prod + (64'd1 << 29)) >> 30) : r_p[k-1];
        end

        if (k < STEPS) begin : g_frac
            always_ff @(posedge i_clk) begin
                r_fr[k] <= r_fr[k-1];
            end
        end
    end

    // final scaling by 2^n, round half up
    logic [32:0] rnd_sum;
    assign rnd_sum = 33'(r_p[STEPS]) + ((r_s[STEPS] != 5'd0) ?
                     (33'd1 << (r_s[STEPS] - 5'd1)) : 33'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[STEPS+1] <= 1'b0;
        end else begin
            r_v[STEPS+1] <= r_v[STEPS];
        end
        r_side[STEPS+1] <= r_side[STEPS];
        r_out           <= (r_s[STEPS] == 5'd0) ? r_p[STEPS] : 32'(rnd_sum >> r_s[STEPS]);
    end

    assign o_valid = r_v[STEPS+1];
    assign o_side  = r_side[STEPS+1];
    assign o_value = r_out;

endmodule

// ----- sv/sme_poly.sv -----
module sme_poly #(
    parameter int STEPS     = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic [31:0]        i_freq,
    input  logic signed [31:0] i_coef [sme_pkg::COEF_REGS],
    input  logic [2:0]         i_terms,
    output logic signed [31:0] o_flux,
    output logic               o_sat
);
    import sme_pkg::*;

    localparam int IW    = 32 - FRAC_BITS;
    localparam int ACC_W = 40;
    localparam int HI_W  = ACC_W + IW;
    localparam int LO_W  = ACC_W + FRAC_BITS;
    localparam int PW    = HI_W + 1;
    localparam int IDX_W = $clog2(COEF_REGS);
    localparam logic signed [ACC_W-1:0] LIM = ACC_W'((64'd1 << 39) - 64'd1);

    logic signed [ACC_W-1:0]  r_acc [0:STEPS];
    logic                     r_sat [0:STEPS];
    logic [IW-1:0]            r_ip  [0:STEPS-1];
    logic [FRAC_BITS-1:0]     r_fp  [0:STEPS-1];
    logic signed [31:0]       r_flux;
    logic                     r_fsat;

    logic [IDX_W-1:0] top_idx;
    assign top_idx = IDX_W'(i_terms - 3'd1);

    always_ff @(posedge i_clk) begin
        r_acc[0] <= (i_terms != 3'd0) ? ACC_W'(i_coef[top_idx]) : '0;
        r_sat[0] <= 1'b0;
        r_ip[0]  <= i_freq[31:FRAC_BITS];
        r_fp[0]  <= i_freq[FRAC_BITS-1:0];
    end

    // Horner step j handles coefficient STEPS-1-j; it is a pass-through
    // when that coefficient is the top term or lies beyond the term count.
    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int IDX = STEPS - 1 - j;

        logic                    act;
        logic [ACC_W-1:0]        mag;
        logic [HI_W-1:0]         ra_hi;
        logic [LO_W-1:0]         ra_lo;
        logic                    ra_neg;
        logic signed [ACC_W-1:0] ra_acc;
        logic                    ra_sat;
        logic [PW-1:0]           prod;
        logic [ACC_W-1:0]        prod_c;
        logic signed [ACC_W-1:0] rb_prod;
        logic                    rb_psat;
        logic signed [ACC_W-1:0] rb_acc;
        logic                    rb_sat;
        logic signed [ACC_W:0]   sum;

        assign act  = {1'b0, i_terms} >= 4'(IDX + 2);
        assign mag  = r_acc[j][ACC_W-1] ? ACC_W'(-r_acc[j]) : ACC_W'(r_acc[j]);
        assign prod = PW'(ra_hi) + PW'((ra_lo + LO_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        assign prod_c = (prod > PW'(LIM)) ? ACC_W'(LIM) : prod[ACC_W-1:0];
        assign sum  = (ACC_W+1)'(rb_prod) + (ACC_W+1)'(i_coef[IDX]);

        always_ff @(posedge i_clk) begin
            ra_hi   <= HI_W'(mag) * HI_W'(r_ip[j]);
            ra_lo   <= LO_W'(mag) * LO_W'(r_fp[j]);
            ra_neg  <= r_acc[j][ACC_W-1];
            ra_acc  <= r_acc[j];
            ra_sat  <= r_sat[j];

            rb_prod <= ra_neg ? -$signed(prod_c) : $signed(prod_c);
            rb_psat <= prod > PW'(LIM);
            rb_acc  <= ra_acc;
            rb_sat  <= ra_sat;

            if (!act) begin
                r_acc[j+1] <= rb_acc;
                r_sat[j+1] <= rb_sat;
            end else if (sum > (ACC_W+1)'(LIM)) begin
                r_acc[j+1] <= LIM;
                r_sat[j+1] <= 1'b1;
            end else if (sum < -(ACC_W+1)'(LIM)) begin
                r_acc[j+1] <= -LIM;
                r_sat[j+1] <= 1'b1;
            end else begin
                r_acc[j+1] <= ACC_W'(sum);
                r_sat[j+1] <= rb_sat | rb_psat;
            end
        end

        if (j < STEPS - 1) begin : g_carry
            logic [IW-1:0]        ra_ip, rb_ip;
            logic [FRAC_BITS-1:0] ra_fp, rb_fp;
            always_ff @(posedge i_clk) begin
                ra_ip      <= r_ip[j];
                ra_fp      <= r_fp[j];
                rb_ip      <= ra_ip;
                rb_fp      <= ra_fp;
                r_ip[j+1]  <= rb_ip;
                r_fp[j+1]  <= rb_fp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_acc[STEPS] > ACC_W'(32'sh7fffffff)) begin
            r_flux <= 32'sh7fffffff;
            r_fsat <= 1'b1;
        end else if (r_acc[STEPS] < ACC_W'(-33'sh80000000)) begin
            r_flux <= -32'sh80000000;
            r_fsat <= 1'b1;
        end else begin
            r_flux <= 32'(r_acc[STEPS]);
            r_fsat <= r_sat[STEPS];
        end
    end

    assign o_flux = r_flux;
    assign o_sat  = r_fsat;

endmodule

// ----- sv/spectral_model_evaluator.sv -----
// Spectral model evaluator: one frequency in, one model flux out.
// Input: raise start with i_frequency (unsigned fixed point); the item is
// transferred at a clock edge with start high and busy low. busy is high only
// during reset and the cycle after it, so a new frequency may follow every cycle.
// Output: o_valid is high for exactly one cycle with o_model_flux and
// o_status (0 ok, 1 saturated, 2 log domain error); results leave in input order.
// A result passes from the start transfer to the o_valid cycle through the
// log unit's input register and its 24 squaring steps, eight stages of
// log-domain arithmetic, the exponential's input register, its 24 root-table
// steps and rounding shift, and the result register. Throughput is one
// item per cycle. Polynomial mode runs in a Horner pipeline beside the log
// unit and is delayed to match the power-law path.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_wdata write one register per
// cycle; write only while no item is in flight.
// Reset (synchronous, active low) restores register defaults and drops all
// items in flight. The receiver cannot stall: results must be taken when shown.
`include "spectral_model_evaluator_macros.svh"

module spectral_model_evaluator #(
    parameter int MAX_TERMS = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [31:0]                       i_frequency,
    output logic                              o_valid,
    output logic signed [31:0]                o_model_flux,
    output logic [1:0]                        o_status,
    input  logic                              i_cfg_we,
    input  logic [sme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_wdata
);
    import sme_pkg::*;

    localparam int TERMS      = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;
    localparam int POLY_STEPS = TERMS - 1;
    localparam int POLY_DLY   = LOG_STEPS - 1 - 3 * POLY_STEPS;
    localparam int LANES      = 3;
    localparam int LANE_FREQ  = 0;
    localparam int LANE_REF   = 1;
    localparam int LANE_C0    = 2;
    localparam int TERM_W     = 42;
    localparam int EX_W       = 44;
    localparam int LATENCY    = 59;
    localparam logic [63:0] TERM_LIMIT = 64'd1 << 40;
    localparam logic signed [EX_W-1:0] EX_BIAS = EX_W'(FRAC_BITS) <<< LOG_FRAC;
    localparam logic signed [EX_W-1:0] N_SAT   = EX_W'(31);
    localparam logic signed [EX_W-1:0] N_LOW   = -EX_W'(1);
    localparam logic signed [EX_W-1:0] N_UNITY = EX_W'(30);

    // ---------------- configuration ----------------
    logic               r_model_mode;
    logic [31:0]        r_ref_freq;
    logic signed [31:0] r_coef [COEF_REGS];
    logic [2:0]         r_term_count;
    logic               r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_mode <= MODE_POWER_LAW;
            r_ref_freq   <= 32'd65536;
            r_coef[0]    <= 32'sd65536;
            r_coef[1]    <= 32'sd0;
            r_coef[2]    <= 32'sd0;
            r_coef[3]    <= 32'sd0;
            r_term_count <= 3'd3;
            r_ready      <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MODE:       r_model_mode <= i_cfg_wdata[0];
                    REG_REF_FREQ:   r_ref_freq   <= i_cfg_wdata;
                    REG_COEF_ZERO:  r_coef[0]    <= i_cfg_wdata;
                    REG_COEF_ONE:   r_coef[1]    <= i_cfg_wdata;
                    REG_COEF_TWO:   r_coef[2]    <= i_cfg_wdata;
                    REG_COEF_THREE: r_coef[3]    <= i_cfg_wdata;
                    REG_TERM_COUNT: r_term_count <= i_cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy = !r_ready;

    logic accept;
    assign accept = start && !busy;

    logic [2:0] terms_used;
    assign terms_used = (r_term_count > 3'(TERMS)) ? 3'(TERMS) : r_term_count;

    // ---------------- log unit ----------------
    logic [31:0]              log_x [LANES];
    logic                     log_v;
    logic signed [LOG_W-1:0]  log_y [LANES];
    logic [31:0]              log_freq;

    assign log_x[LANE_FREQ] = i_frequency;
    assign log_x[LANE_REF]  = r_ref_freq;
    assign log_x[LANE_C0]   = $unsigned(r_coef[0]);

    sme_log2 #(
        .LANES     (LANES),
        .SIDE_W    (32),
        .FRAC_BITS (FRAC_BITS)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_x     (log_x),
        .i_side  (i_frequency),
        .o_valid (log_v),
        .o_log   (log_y),
        .o_side  (log_freq)
    );

    // ---------------- polynomial path ----------------
    logic signed [31:0] poly_flux;
    logic               poly_sat;
    t_poly_res          r_pdly [0:POLY_DLY-1];

    sme_poly #(
        .STEPS     (POLY_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_freq  (i_frequency),
        .i_coef  (r_coef),
        .i_terms (terms_used),
        .o_flux  (poly_flux),
        .o_sat   (poly_sat)
    );

    always_ff @(posedge i_clk) begin
        r_pdly[0] <= '{flux: poly_flux, sat: poly_sat};
        for (int i = 1; i < POLY_DLY; i++) begin
            r_pdly[i] <= r_pdly[i-1];
        end
    end

    // ---------------- log-domain arithmetic ----------------
    function automatic logic signed [TERM_W-1:0] term_finish(input logic [63:0] hi,
                                                             input logic [63:0] lo,
                                                             input logic neg);
        logic [63:0] mag;
        mag = (hi << (LOG_FRAC - FRAC_BITS)) + ((lo + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        if (mag > TERM_LIMIT) begin
            mag = TERM_LIMIT;
        end
        return neg ? -$signed(TERM_W'(mag)) : $signed(TERM_W'(mag));
    endfunction

    logic [8:1] r_v;
    logic signed [LOG_W:0]    r1_l2;
    logic signed [LOG_W-1:0]  r1_lc, r2_lc, r3_lc, r4_lc, r5_lc, r6_lc, r7_lc;
    logic                     r1_dom, r2_dom, r3_dom, r4_dom, r5_dom, r6_dom, r7_dom, r8_dom;
    t_poly_res                r1_pr, r2_pr, r3_pr, r4_pr, r5_pr, r6_pr, r7_pr, r8_pr;
    logic [61:0]              r2_sq;
    logic [38:0]              r2_p1hi;
    logic [55:0]              r2_p1lo;
    logic                     r2_neg1;
    logic [35:0]              r3_sq;
    logic signed [TERM_W-1:0] r3_t1, r4_t1, r5_t1, r6_t1, r7_t1;
    logic [59:0]              r4_qraw;
    logic [35:0]              r5_q;
    logic [43:0]              r6_p2hi;
    logic [55:0]              r6_p2lo;
    logic                     r6_neg2;
    logic signed [TERM_W-1:0] r7_t2;
    logic signed [EX_W-1:0]   r8_ex;

    logic [LOG_W:0] ul;
    logic [31:0]    ma1, ma2;
    assign ul  = r1_l2[LOG_W] ? (LOG_W+1)'(-r1_l2) : (LOG_W+1)'(r1_l2);
    assign ma1 = r_coef[1][31] ? 32'(-r_coef[1]) : 32'(r_coef[1]);
    assign ma2 = r_coef[2][31] ? 32'(-r_coef[2]) : 32'(r_coef[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[7:1], log_v};
        end

        r1_l2  <= (LOG_W+1)'(log_y[LANE_FREQ]) - (LOG_W+1)'(log_y[LANE_REF]);
        r1_lc  <= log_y[LANE_C0];
        r1_dom <= (log_freq == 32'd0) || (r_coef[0] <= 32'sd0) || (r_ref_freq == 32'd0);
        r1_pr  <= r_pdly[POLY_DLY-1];

        r2_sq   <= 62'(ul) * 62'(ul);
        r2_p1hi <= 39'(ma1) * 39'(ul[LOG_W:LOG_FRAC]);
        r2_p1lo <= 56'(ma1) * 56'(ul[LOG_FRAC-1:0]);
        r2_neg1 <= r_coef[1][31] ^ r1_l2[LOG_W];
        r2_lc   <= r1_lc;
        r2_dom  <= r1_dom;
        r2_pr   <= r1_pr;

        r3_sq  <= 36'((r2_sq + (62'd1 << (LOG_FRAC - 1))) >> LOG_FRAC);
        r3_t1  <= term_finish(64'(r2_p1hi), 64'(r2_p1lo), r2_neg1);
        r3_lc  <= r2_lc;
        r3_dom <= r2_dom;
        r3_pr  <= r2_pr;

        r4_qraw <= 60'(r3_sq) * 60'(LN2_Q24);
        r4_t1   <= r3_t1;
        r4_lc   <= r3_lc;
        r4_dom  <= r3_dom;
        r4_pr   <= r3_pr;

        r5_q   <= 36'((r4_qraw + (60'd1 << (LOG_FRAC - 1))) >> LOG_FRAC);
        r5_t1  <= r4_t1;
        r5_lc  <= r4_lc;
        r5_dom <= r4_dom;
        r5_pr  <= r4_pr;

        r6_p2hi <= 44'(ma2) * 44'(r5_q[35:LOG_FRAC]);
        r6_p2lo <= 56'(ma2) * 56'(r5_q[LOG_FRAC-1:0]);
        r6_neg2 <= r_coef[2][31];
        r6_t1   <= r5_t1;
        r6_lc   <= r5_lc;
        r6_dom  <= r5_dom;
        r6_pr   <= r5_pr;

        r7_t2  <= term_finish(64'(r6_p2hi), 64'(r6_p2lo), r6_neg2);
        r7_t1  <= r6_t1;
        r7_lc  <= r6_lc;
        r7_dom <= r6_dom;
        r7_pr  <= r6_pr;

        r8_ex  <= EX_W'(r7_lc) + EX_W'(r7_t1) + EX_W'(r7_t2) + EX_BIAS;
        r8_dom <= r7_dom;
        r8_pr  <= r7_pr;
    end

    // ---------------- exponent split and special cases ----------------
    logic signed [EX_W-1:0] ex_int;
    logic signed [EX_W-1:0] shift_full;
    t_override              ovr;

    assign ex_int     = r8_ex >>> LOG_FRAC;
    assign shift_full = N_UNITY - ex_int;

    always_comb begin
        ovr = '{fixed: 1'b0, flux: 32'd0, status: ST_OK};
        if (r_model_mode == MODE_POLYNOMIAL) begin
            ovr = '{fixed: 1'b1, flux: r8_pr.flux, status: r8_pr.sat ? ST_SAT : ST_OK};
        end else if (r8_dom) begin
            ovr = '{fixed: 1'b1, flux: 32'd0, status: ST_DOMAIN};
        end else if (ex_int >= N_SAT) begin
            ovr = '{fixed: 1'b1, flux: 32'h7fffffff, status: ST_SAT};
        end else if (ex_int < N_LOW) begin
            ovr = '{fixed: 1'b1, flux: 32'd0, status: ST_OK};
        end
    end

    logic        exp_v;
    logic [31:0] exp_val;
    t_override   exp_ovr;

    sme_exp2 #(
        .SIDE_W ($bits(t_override))
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[8]),
        .i_frac  (r8_ex[LOG_FRAC-1:0]),
        .i_shift (shift_full[4:0]),
        .i_side  (ovr),
        .o_valid (exp_v),
        .o_value (exp_val),
        .o_side  (exp_ovr)
    );

    // ---------------- result register ----------------
    logic               r_o_valid;
    logic signed [31:0] r_o_flux;
    t_status            r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= exp_v;
        end
        if (exp_ovr.fixed) begin
            r_o_flux   <= exp_ovr.flux;
            r_o_status <= exp_ovr.status;
        end else if (exp_val > 32'h7fffffff) begin
            r_o_flux   <= 32'sh7fffffff;
            r_o_status <= ST_SAT;
        end else begin
            r_o_flux   <= exp_val;
            r_o_status <= ST_OK;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_model_flux = r_o_flux;
    assign o_status     = r_o_status;

    // o_valid is sampled after the edge that sets it, hence the + 1 in the $past depth
    `SME_ASSERT_IMP(a_latency, o_valid, $past(accept, LATENCY + 1))
    `SME_ASSERT_IMP(a_domain_power_law, o_valid && o_status == ST_DOMAIN, r_model_mode == MODE_POWER_LAW && o_model_flux == 32'sd0)
    `SME_ASSERT_IMP(a_power_law_sign, o_valid && r_model_mode == MODE_POWER_LAW, !o_model_flux[31])
    `SME_ASSERT_IMP(a_power_law_sat, o_valid && r_model_mode == MODE_POWER_LAW && o_status == ST_SAT, o_model_flux == 32'sh7fffffff)
    `SME_ASSERT_NXT(a_pipe_to_output, exp_v, o_valid && o_status != 2'd3)

endmodule
